// ===== rtl/core/first_fit_heap_allocator_defines.svh =====
// assertion macros for the first-fit heap allocator
// used by the top level only, expects clk and rst in scope
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha check failed");

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha check failed");

`endif

// ===== rtl/core/ffha_pkg.sv =====
// types and codes shared by the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] req_size;
    logic [15:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] grant_addr;
    logic [15:0] copy_bytes;
  } rsp_t;

  // one block of heap: start address and length in bytes
  typedef struct packed {
    logic [16:0] len;
    logic [15:0] start;
  } blk_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// first-fit heap allocator with coalescing free table, top level
// depends on ffha_pkg, ffha_ram and first_fit_heap_allocator_defines.svh
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (ffha_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (ffha_pkg::rsp_t)
//
// one request at a time; a request walks the live table (on lookup and on slot
// search) and the segment table (for scan, shift up and shift down), all through
// one read port per ram.
// after reset the init state writes the initial segment before the first request.
// a finished result sits in the output register while the next request runs.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES    = 65536,
  parameter int MAX_FREE_SEGS = 64,
  parameter int MAX_LIVE      = 64,
  parameter int HDR_BYTES     = 16,
  parameter int MIN_SEG       = 16,
  parameter int BLOCK_HDR     = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ffha_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ffha_pkg::rsp_t     rsp
);

  localparam int SW = $clog2(MAX_FREE_SEGS);
  localparam int CW = $clog2(MAX_FREE_SEGS + 1);
  localparam int LW = $clog2(MAX_LIVE);
  localparam logic [16:0] HDR   = 17'(HDR_BYTES);
  localparam logic [16:0] MINS  = 17'(MIN_SEG);
  localparam logic [15:0] BHDR  = 16'(BLOCK_HDR);
  localparam logic [16:0] INITL = 17'(HEAP_BYTES - BLOCK_HDR);
  localparam logic [CW-1:0] SEGMAX = CW'(MAX_FREE_SEGS);
  localparam logic [LW-1:0] LLAST  = LW'(MAX_LIVE - 1);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LK_RD   = 4'd2;
  localparam logic [3:0] S_LK_CMP  = 4'd3;
  localparam logic [3:0] S_SLOT    = 4'd4;
  localparam logic [3:0] S_SG_RD   = 4'd5;
  localparam logic [3:0] S_SG_CMP  = 4'd6;
  localparam logic [3:0] S_RM_RD   = 4'd7;
  localparam logic [3:0] S_RM_WR   = 4'd8;
  localparam logic [3:0] S_POST    = 4'd9;
  localparam logic [3:0] S_FR_RD   = 4'd10;
  localparam logic [3:0] S_FR_CMP  = 4'd11;
  localparam logic [3:0] S_FR_EVAL = 4'd12;
  localparam logic [3:0] S_UP_RD   = 4'd13;
  localparam logic [3:0] S_UP_WR   = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  logic [3:0]          state;
  ffha_pkg::req_t      cur_req;
  logic [16:0]         total;
  logic                rlv;
  logic                rm_free;
  logic [LW-1:0]       lidx;
  logic [LW-1:0]       old_slot;
  logic [LW-1:0]       new_slot;
  ffha_pkg::blk_t      old;
  ffha_pkg::blk_t      prev;
  ffha_pkg::blk_t      cur;
  logic                has_cur;
  logic [CW-1:0]       seg_count;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       pos;
  logic [2:0]          st;
  logic [15:0]         grant;
  logic [15:0]         copy;
  logic [MAX_LIVE-1:0] live_valid;

  logic                seg_we;
  logic [SW-1:0]       seg_waddr;
  ffha_pkg::blk_t      seg_wdata;
  logic [CW-1:0]       seg_ridx;
  ffha_pkg::blk_t      seg_rdata;
  logic                live_we;
  ffha_pkg::blk_t      live_wdata;
  ffha_pkg::blk_t      live_rdata;

  logic [16:0] sz1;
  logic [16:0] tot_raw;
  logic [15:0] target;
  logic        fits;
  logic        split;
  logic        lo;
  logic        hi;
  logic        req_acc;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  assign sz1     = (req.req_size == 16'd0) ? 17'd1 : {1'b0, req.req_size};
  assign tot_raw = sz1 + HDR;
  assign target  = cur_req.req_addr - HDR[15:0];
  assign fits    = (seg_rdata.len >= total);
  assign split   = ((seg_rdata.len - total) >= MINS);
  assign lo = (cnt != '0) && (({1'b0, prev.start} + prev.len) == {1'b0, old.start});
  assign hi = has_cur && (({1'b0, old.start} + old.len) == {1'b0, cur.start});

  // segment ram addressing
  always_comb begin
    case (state)
      S_RM_RD: seg_ridx = cnt + CW'(1);
      S_UP_RD: seg_ridx = cnt - CW'(1);
      default: seg_ridx = cnt;
    endcase
  end

  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = cnt[SW-1:0];
    seg_wdata = seg_rdata;
    case (state)
      S_INIT: begin
        seg_we    = 1'b1;
        seg_waddr = '0;
        seg_wdata = '{len: INITL, start: BHDR};
      end
      S_SG_CMP: begin
        if (fits && split) begin
          seg_we    = 1'b1;
          seg_wdata = '{len: seg_rdata.len - total,
                        start: seg_rdata.start + total[15:0]};
        end
      end
      S_RM_WR: begin
        seg_we = 1'b1;
      end
      S_FR_EVAL: begin
        if (lo) begin
          seg_we    = 1'b1;
          seg_waddr = SW'(cnt - CW'(1));
          seg_wdata = '{len: prev.len + old.len + (hi ? cur.len : 17'd0),
                        start: prev.start};
        end else if (hi) begin
          seg_we    = 1'b1;
          seg_wdata = '{len: cur.len + old.len, start: old.start};
        end
      end
      S_UP_RD: begin
        if (cnt == pos) begin
          seg_we    = 1'b1;
          seg_wdata = old;
        end
      end
      S_UP_WR: begin
        seg_we = 1'b1;
      end
      default: begin
        seg_we = 1'b0;
      end
    endcase
  end

  assign live_we    = (state == S_SG_CMP) && fits;
  assign live_wdata = '{len: split ? total : seg_rdata.len, start: seg_rdata.start};

  ffha_ram #(.WIDTH($bits(ffha_pkg::blk_t)), .DEPTH(MAX_FREE_SEGS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_ridx[SW-1:0]),
    .rdata (seg_rdata)
  );

  ffha_ram #(.WIDTH($bits(ffha_pkg::blk_t)), .DEPTH(MAX_LIVE)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (new_slot),
    .wdata (live_wdata),
    .raddr (lidx),
    .rdata (live_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      seg_count  <= CW'(1);
      live_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // the done state reloads the output beat itself
      if ((state != S_DONE) && rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_acc) begin
            cur_req <= req;
            total   <= (tot_raw < MINS) ? MINS : tot_raw;
            lidx    <= '0;
            rlv     <= 1'b0;
            grant   <= '0;
            copy    <= '0;
            case (req.req_type)
              ffha_pkg::REQ_ALLOC: begin
                state <= S_SLOT;
              end
              ffha_pkg::REQ_FREE, ffha_pkg::REQ_REALLOC: begin
                if (req.req_addr == 16'd0) begin
                  if (req.req_type == ffha_pkg::REQ_FREE) begin
                    st    <= ffha_pkg::ST_IGNORED;
                    state <= S_DONE;
                  end else begin
                    state <= S_SLOT;
                  end
                end else if ({1'b0, req.req_addr} < HDR) begin
                  st    <= ffha_pkg::ST_UNKNOWN;
                  state <= S_DONE;
                end else begin
                  state <= S_LK_RD;
                end
              end
              default: begin
                st    <= ffha_pkg::ST_IGNORED;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LK_RD: begin
          if (live_valid[lidx]) begin
            state <= S_LK_CMP;
          end else if (lidx == LLAST) begin
            st    <= ffha_pkg::ST_UNKNOWN;
            state <= S_DONE;
          end else begin
            lidx <= lidx + LW'(1);
          end
        end
        S_LK_CMP: begin
          if (live_rdata.start == target) begin
            old_slot <= lidx;
            old      <= live_rdata;
            if (cur_req.req_type == ffha_pkg::REQ_FREE) begin
              cnt     <= '0;
              has_cur <= 1'b0;
              state   <= S_FR_RD;
            end else begin
              rlv   <= 1'b1;
              lidx  <= '0;
              state <= S_SLOT;
            end
          end else if (lidx == LLAST) begin
            st    <= ffha_pkg::ST_UNKNOWN;
            state <= S_DONE;
          end else begin
            lidx  <= lidx + LW'(1);
            state <= S_LK_RD;
          end
        end
        S_SLOT: begin
          if (!live_valid[lidx]) begin
            new_slot <= lidx;
            cnt      <= '0;
            state    <= S_SG_RD;
          end else if (lidx == LLAST) begin
            st    <= ffha_pkg::ST_OOM;
            state <= S_DONE;
          end else begin
            lidx <= lidx + LW'(1);
          end
        end
        S_SG_RD: begin
          if (cnt >= seg_count) begin
            st    <= ffha_pkg::ST_OOM;
            state <= S_DONE;
          end else begin
            state <= S_SG_CMP;
          end
        end
        S_SG_CMP: begin
          if (fits) begin
            live_valid[new_slot] <= 1'b1;
            grant                <= seg_rdata.start + HDR[15:0];
            if (split) begin
              state <= S_POST;
            end else begin
              rm_free <= 1'b0;
              state   <= S_RM_RD;
            end
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_SG_RD;
          end
        end
        S_RM_RD: begin
          if ((cnt + CW'(1)) >= seg_count) begin
            seg_count <= seg_count - CW'(1);
            if (rm_free) begin
              live_valid[old_slot] <= 1'b0;
              st                   <= ffha_pkg::ST_OK;
              state                <= S_DONE;
            end else begin
              state <= S_POST;
            end
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          cnt   <= cnt + CW'(1);
          state <= S_RM_RD;
        end
        S_POST: begin
          if (rlv) begin
            copy    <= 16'(old.len - HDR);
            cnt     <= '0;
            has_cur <= 1'b0;
            state   <= S_FR_RD;
          end else begin
            st    <= ffha_pkg::ST_OK;
            state <= S_DONE;
          end
        end
        S_FR_RD: begin
          if (cnt >= seg_count) begin
            state <= S_FR_EVAL;
          end else begin
            state <= S_FR_CMP;
          end
        end
        S_FR_CMP: begin
          if (seg_rdata.start < old.start) begin
            prev  <= seg_rdata;
            cnt   <= cnt + CW'(1);
            state <= S_FR_RD;
          end else begin
            cur     <= seg_rdata;
            has_cur <= 1'b1;
            state   <= S_FR_EVAL;
          end
        end
        S_FR_EVAL: begin
          if (lo && hi) begin
            // merged into the lower one, drop the upper neighbour
            rm_free <= 1'b1;
            state   <= S_RM_RD;
          end else if (lo || hi) begin
            live_valid[old_slot] <= 1'b0;
            st                   <= ffha_pkg::ST_OK;
            state                <= S_DONE;
          end else if (seg_count >= SEGMAX) begin
            st    <= ffha_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            pos   <= cnt;
            cnt   <= seg_count;
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          if (cnt == pos) begin
            seg_count            <= seg_count + CW'(1);
            live_valid[old_slot] <= 1'b0;
            st                   <= ffha_pkg::ST_OK;
            state                <= S_DONE;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          cnt   <= cnt - CW'(1);
          state <= S_UP_RD;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp_valid || !rsp_stall)) begin
      rsp <= '{status: st, grant_addr: grant, copy_bytes: copy};
    end
  end

  // a taken request keeps the input side closed on the next cycle
  `FFHA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  // the free table never holds more than its capacity
  `FFHA_ASSERT_NOW(a_seg_bound, state != S_INIT, seg_count <= SEGMAX)
  // a result is only loaded from the done state
  `FFHA_ASSERT_NXT(a_rsp_source, !rsp_valid && state != S_DONE, !rsp_valid)

endmodule
`default_nettype wire
